>>> hw/rtl/node_liveness_table_top_macros.svh
// Assertion macros used by the liveness table top module.
`ifndef NODE_LIVENESS_TABLE_TOP_MACROS_SVH
`define NODE_LIVENESS_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nlt_pkg.sv
package nlt_pkg;

    localparam int NODES = 16;
    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int TIME_W = 32;
    localparam logic [7:0] BROADCAST_ID = 8'd255;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  node_id;
        logic [31:0] ntp_time;
        logic [31:0] message_time;
        logic [31:0] now_ms;
    } nlt_in_t;

    typedef struct packed {
        logic [7:0] server_id;
        logic [4:0] next_free_id;
        logic [7:0] oldest_ntp_id;
        logic [4:0] node_count;
        logic       rejected;
    } nlt_out_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  id;
        logic [TIME_W-1:0] ntp;
        logic [TIME_W-1:0] msg;
        logic [TIME_W-1:0] now;
    } nlt_upd_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] id;
    } nlt_prune_t;

    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  hi_idx;
        logic              hi_alive;
        logic              server_found;
        logic [IDX_W-1:0]  server_id;
        logic              dead_found;
        logic [IDX_W-1:0]  first_dead;
        logic [TIME_W-1:0] min_ntp;
        logic [IDX_W-1:0]  old_id;
    } nlt_acc_t;

endpackage

>>> hw/rtl/node_liveness_table_top.sv
// Flow: an accepted request sets a launch register, then the scan token walks the 16 entry
// cells, one cell per cycle, and done and the result are registered from the last cell.
// Busy: no new request is taken while busy; busy rises after start and falls as the scan
// token leaves the last cell, in the cycle in which done is high.
// Reset: all entries absent and dead, death timeout 10000 ms, no result pending.
// The receiver cannot stall; each result is valid only in its done cycle.
`include "node_liveness_table_top_macros.svh"

module node_liveness_table_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  nlt_pkg::nlt_in_t   request,
    output logic               done,
    output nlt_pkg::nlt_out_t  result,
    input  logic               timeout_we,
    input  logic [31:0]        timeout_wdata
);

    logic                       accept;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       launch_reg;
    logic                       done_reg;
    logic                       bad_id;
    logic                       rejected_reg;
    logic [nlt_pkg::TIME_W-1:0] now_reg;
    logic [nlt_pkg::TIME_W-1:0] timeout_reg;
    nlt_pkg::nlt_upd_t          upd;
    nlt_pkg::nlt_prune_t        prune;
    nlt_pkg::nlt_acc_t          head;
    nlt_pkg::nlt_acc_t          chain [nlt_pkg::NODES+1];
    nlt_pkg::nlt_acc_t          tail;
    logic                       do_prune;
    logic [nlt_pkg::CNT_W-1:0]  count_fin;
    logic [nlt_pkg::CNT_W-1:0]  next_free_fin;
    nlt_pkg::nlt_out_t          result_next;
    nlt_pkg::nlt_out_t          result_reg;

    assign accept = start && !busy_reg;
    assign bad_id = (request.node_id == nlt_pkg::BROADCAST_ID)
                 || (32'(request.node_id) >= 32'(nlt_pkg::NODES));

    always_comb
    begin
        upd.valid = accept && (request.opcode == nlt_pkg::OP_REPORT) && !bad_id;
        upd.id    = request.node_id[nlt_pkg::IDX_W-1:0];
        upd.ntp   = request.ntp_time;
        upd.msg   = request.message_time;
        upd.now   = request.now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= nlt_pkg::TIMEOUT_RESET;
        end
        else if (timeout_we)
        begin
            timeout_reg <= timeout_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg      <= request.now_ms;
            rejected_reg <= (request.opcode == nlt_pkg::OP_REPORT) && bad_id;
        end
    end

    assign tail = chain[nlt_pkg::NODES];

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
            done_reg   <= tail.valid;
        end
    end

    always_comb
    begin
        head         = '0;
        head.valid   = launch_reg;
        head.min_ntp = now_reg;
    end

    assign chain[0] = head;

    for (genvar g = 0; g < nlt_pkg::NODES; g++)
    begin : g_cell
        nlt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (nlt_pkg::IDX_W'(g)),
            .upd     (upd),
            .now     (now_reg),
            .timeout (timeout_reg),
            .prune   (prune),
            .acc_in  (chain[g]),
            .acc_out (chain[g+1])
        );
    end

    // The highest present entry leaves only when dead and not also the lowest one.
    always_comb
    begin
        do_prune    = tail.valid && (tail.count >= nlt_pkg::CNT_W'(2)) && !tail.hi_alive;
        prune.valid = do_prune;
        prune.id    = tail.hi_idx;
        count_fin   = do_prune ? (tail.count - 1'b1) : tail.count;
        if (tail.dead_found && !(do_prune && (tail.first_dead == tail.hi_idx)))
        begin
            next_free_fin = nlt_pkg::CNT_W'(tail.first_dead);
        end
        else
        begin
            next_free_fin = count_fin;
        end
        result_next.server_id     = tail.server_found ? 8'(tail.server_id)
                                                      : nlt_pkg::BROADCAST_ID;
        result_next.next_free_id  = 5'(next_free_fin);
        result_next.oldest_ntp_id = 8'(tail.old_id);
        result_next.node_count    = 5'(count_fin);
        result_next.rejected      = rejected_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `NLT_ASSERT_NOW(a_idle_no_token, !busy_reg, !tail.valid, "scan token seen while idle")
    `NLT_ASSERT_NEXT(a_start_busy, accept, busy_reg && !done_reg, "start did not raise busy")
    `NLT_ASSERT_NOW(a_server_count, done_reg && (result_reg.server_id != nlt_pkg::BROADCAST_ID),
        result_reg.node_count != 5'd0, "alive server reported with empty table")

endmodule

>>> hw/rtl/nlt_cell.sv
module nlt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [nlt_pkg::IDX_W-1:0]  idx,
    input  nlt_pkg::nlt_upd_t          upd,
    input  logic [nlt_pkg::TIME_W-1:0] now,
    input  logic [nlt_pkg::TIME_W-1:0] timeout,
    input  nlt_pkg::nlt_prune_t        prune,
    input  nlt_pkg::nlt_acc_t          acc_in,
    output nlt_pkg::nlt_acc_t          acc_out
);

    logic                       present_reg;
    logic                       alive_reg;
    logic [nlt_pkg::TIME_W-1:0] last_msg_reg;
    logic [nlt_pkg::TIME_W-1:0] last_ntp_reg;
    logic [nlt_pkg::TIME_W-1:0] deadline;
    logic                       expired;
    logic                       alive_aged;
    logic                       upd_hit;
    logic                       prune_hit;
    nlt_pkg::nlt_acc_t          acc_next;
    nlt_pkg::nlt_acc_t          acc_reg;

    assign deadline   = last_msg_reg + timeout;
    assign expired    = alive_reg && (now > deadline);
    assign alive_aged = alive_reg && !expired;
    assign upd_hit    = upd.valid && (upd.id == idx);
    assign prune_hit  = prune.valid && (prune.id == idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            alive_reg   <= 1'b0;
        end
        else if (upd_hit)
        begin
            present_reg <= 1'b1;
            alive_reg   <= 1'b1;
        end
        else if (prune_hit)
        begin
            present_reg <= 1'b0;
            alive_reg   <= 1'b0;
        end
        else if (acc_in.valid && present_reg)
        begin
            alive_reg <= alive_aged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_hit)
        begin
            if (upd.msg != '0)
            begin
                last_msg_reg <= upd.msg;
            end
            else if (!present_reg)
            begin
                last_msg_reg <= upd.now;
            end
            if (upd.ntp != '0)
            begin
                last_ntp_reg <= upd.ntp;
            end
            else if (!present_reg)
            begin
                last_ntp_reg <= '0;
            end
        end
    end

    always_comb
    begin
        acc_next = acc_in;
        if (present_reg)
        begin
            acc_next.count    = acc_in.count + 1'b1;
            acc_next.hi_idx   = idx;
            acc_next.hi_alive = alive_aged;
            if (alive_aged)
            begin
                if (!acc_in.server_found)
                begin
                    acc_next.server_found = 1'b1;
                    acc_next.server_id    = idx;
                end
                if (last_ntp_reg <= acc_in.min_ntp)
                begin
                    acc_next.min_ntp = last_ntp_reg;
                    acc_next.old_id  = idx;
                end
            end
            else if (!acc_in.dead_found)
            begin
                acc_next.dead_found = 1'b1;
                acc_next.first_dead = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

>>> tb/node_liveness_table_top_tb.sv
`timescale 1ns / 1ps

module node_liveness_table_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 225;

    typedef struct {
        nlt_pkg::nlt_in_t  req;
        bit                typed;
        nlt_pkg::nlt_out_t want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    nlt_pkg::nlt_in_t  request = '0;
    logic              done;
    nlt_pkg::nlt_out_t result;
    logic              timeout_we = 1'b0;
    logic [31:0]       timeout_wdata = '0;

    logic        tbl_present [nlt_pkg::NODES];
    logic        tbl_alive [nlt_pkg::NODES];
    logic [31:0] tbl_last_msg [nlt_pkg::NODES];
    logic [31:0] tbl_last_ntp [nlt_pkg::NODES];
    logic [31:0] model_timeout;

    nlt_pkg::nlt_out_t pending_results [$];
    stim_row_t         directed_rows [$];
    logic [31:0]       cur_ms;
    int                sender_idle_pct;
    int                errors = 0;
    int                results_seen = 0;
    int                directed_count = 0;
    int                random_count = 0;
    int                timeout_writes = 0;

    node_liveness_table_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic nlt_pkg::nlt_in_t make_req(logic op, logic [7:0] id, logic [31:0] ntp,
                                                  logic [31:0] msg, logic [31:0] now);
        nlt_pkg::nlt_in_t it;
        it.opcode = op;
        it.node_id = id;
        it.ntp_time = ntp;
        it.message_time = msg;
        it.now_ms = now;
        return it;
    endfunction

    function automatic nlt_pkg::nlt_out_t result_of(logic [7:0] server, logic [4:0] next_free,
                                                    logic [7:0] oldest, logic [4:0] count,
                                                    logic rej);
        nlt_pkg::nlt_out_t r;
        r.server_id = server;
        r.next_free_id = next_free;
        r.oldest_ntp_id = oldest;
        r.node_count = count;
        r.rejected = rej;
        return r;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < nlt_pkg::NODES; i++)
        begin
            tbl_present[i] = 1'b0;
            tbl_alive[i] = 1'b0;
            tbl_last_msg[i] = '0;
            tbl_last_ntp[i] = '0;
        end
        model_timeout = nlt_pkg::TIMEOUT_RESET;
    endfunction

    function automatic nlt_pkg::nlt_out_t predict_liveness(nlt_pkg::nlt_in_t it);
        nlt_pkg::nlt_out_t r;
        int                lo;
        int                hi;
        int                idx;
        int                cnt;
        logic              dead_found;
        logic              server_found;
        logic [31:0]       min_ntp;
        logic [31:0]       deadline;
        r = result_of(nlt_pkg::BROADCAST_ID, 5'd0, 8'd0, 5'd0, 1'b0);
        lo = -1;
        hi = -1;
        cnt = 0;
        dead_found = 1'b0;
        server_found = 1'b0;
        min_ntp = it.now_ms;
        if (it.opcode == nlt_pkg::OP_REPORT)
        begin
            if (it.node_id == nlt_pkg::BROADCAST_ID || int'(it.node_id) >= nlt_pkg::NODES)
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                idx = int'(it.node_id);
                if (!tbl_present[idx])
                begin
                    tbl_present[idx] = 1'b1;
                    tbl_last_msg[idx] = it.now_ms;
                    tbl_last_ntp[idx] = '0;
                end
                tbl_alive[idx] = 1'b1;
                if (it.ntp_time != 0)
                begin
                    tbl_last_ntp[idx] = it.ntp_time;
                end
                if (it.message_time != 0)
                begin
                    tbl_last_msg[idx] = it.message_time;
                end
            end
        end
        for (int i = 0; i < nlt_pkg::NODES; i++)
        begin
            if (tbl_present[i])
            begin
                deadline = tbl_last_msg[i] + model_timeout;
                if (tbl_alive[i] && it.now_ms > deadline)
                begin
                    tbl_alive[i] = 1'b0;
                end
                if (lo < 0)
                begin
                    lo = i;
                end
                hi = i;
            end
        end
        if (hi >= 0 && hi != lo && !tbl_alive[hi])
        begin
            tbl_present[hi] = 1'b0;
            tbl_alive[hi] = 1'b0;
        end
        for (int i = 0; i < nlt_pkg::NODES; i++)
        begin
            if (tbl_present[i])
            begin
                cnt++;
                if (tbl_alive[i])
                begin
                    if (!server_found)
                    begin
                        server_found = 1'b1;
                        r.server_id = 8'(i);
                    end
                    if (tbl_last_ntp[i] <= min_ntp)
                    begin
                        min_ntp = tbl_last_ntp[i];
                        r.oldest_ntp_id = 8'(i);
                    end
                end
                else if (!dead_found)
                begin
                    dead_found = 1'b1;
                    r.next_free_id = 5'(i);
                end
            end
        end
        if (!dead_found)
        begin
            r.next_free_id = 5'(cnt);
        end
        r.node_count = 5'(cnt);
        return r;
    endfunction

    task automatic send_transfer(nlt_pkg::nlt_in_t it, bit typed, nlt_pkg::nlt_out_t typed_want);
        int                gap;
        nlt_pkg::nlt_out_t predicted;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predicted = predict_liveness(it);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic write_timeout(logic [31:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
        timeout_we <= 1'b1;
        timeout_wdata <= value;
        @(posedge clk);
        timeout_we <= 1'b0;
        model_timeout = value;
        timeout_writes++;
    endtask

    function automatic nlt_pkg::nlt_in_t random_item();
        nlt_pkg::nlt_in_t it;
        int unsigned      pick;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: cur_ms = cur_ms + $urandom_range(200);
            12, 13, 14, 15, 16: cur_ms = cur_ms + $urandom_range(3000);
            17, 18: cur_ms = cur_ms + $urandom_range(20000);
            default: cur_ms = $urandom();
        endcase
        it.now_ms = cur_ms;
        it.opcode = ($urandom_range(99) < 75) ? nlt_pkg::OP_REPORT : nlt_pkg::OP_TICK;
        pick = $urandom_range(99);
        if (it.opcode == nlt_pkg::OP_TICK)
        begin
            it.node_id = 8'($urandom_range(255));
        end
        else if (pick < 88)
        begin
            it.node_id = 8'($urandom_range(nlt_pkg::NODES - 1));
        end
        else if (pick < 94)
        begin
            it.node_id = nlt_pkg::BROADCAST_ID;
        end
        else
        begin
            it.node_id = 8'($urandom_range(nlt_pkg::NODES, 254));
        end
        case ($urandom_range(9))
            0, 1, 2: it.ntp_time = '0;
            3, 4, 5, 6: it.ntp_time = cur_ms - $urandom_range(500);
            7: it.ntp_time = cur_ms + $urandom_range(1, 500);
            8: it.ntp_time = $urandom();
            default: it.ntp_time = cur_ms & 32'hFFFF_FC00;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: it.message_time = '0;
            5, 6, 7: it.message_time = cur_ms - $urandom_range(2000);
            8: it.message_time = $urandom();
            default: it.message_time = cur_ms;
        endcase
        return it;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        nlt_pkg::nlt_out_t want;
        forever
        begin
            @(posedge clk);
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("server_id", 32'(want.server_id), 32'(result.server_id));
                    check_field("next_free_id", 32'(want.next_free_id),
                                32'(result.next_free_id));
                    check_field("oldest_ntp_id", 32'(want.oldest_ntp_id),
                                32'(result.oldest_ntp_id));
                    check_field("node_count", 32'(want.node_count), 32'(result.node_count));
                    check_field("rejected", 32'(want.rejected), 32'(result.rejected));
                end
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                stall = 0;
            end
            else
            begin
                stall++;
            end
        end
        $display("Watchdog expired after %0d cycles without a transfer.", STALL_LIMIT);
        $display("[node_liveness_table_top] ERROR");
        $finish;
    end

    task automatic push_row(logic op, logic [7:0] id, logic [31:0] ntp, logic [31:0] msg,
                            logic [31:0] now, bit typed, nlt_pkg::nlt_out_t want);
        stim_row_t row;
        row.req = make_req(op, id, ntp, msg, now);
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        logic [31:0]       phase_timeout [PHASES];
        int                phase_idle [PHASES];
        nlt_pkg::nlt_out_t empty_ok;
        nlt_pkg::nlt_out_t empty_rej;
        empty_ok = result_of(nlt_pkg::BROADCAST_ID, 5'd0, 8'd0, 5'd0, 1'b0);
        empty_rej = result_of(nlt_pkg::BROADCAST_ID, 5'd0, 8'd0, 5'd0, 1'b1);

        push_row(nlt_pkg::OP_TICK, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1, empty_ok);
        push_row(nlt_pkg::OP_REPORT, nlt_pkg::BROADCAST_ID, 32'd1, 32'd1, 32'd5, 1, empty_rej);
        push_row(nlt_pkg::OP_REPORT, 8'd16, 32'd0, 32'd0, 32'd6, 1, empty_rej);
        push_row(nlt_pkg::OP_REPORT, 8'd254, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1,
                 empty_rej);
        push_row(nlt_pkg::OP_REPORT, 8'd0, 32'd0, 32'd0, 32'd100, 1,
                 result_of(8'd0, 5'd1, 8'd0, 5'd1, 1'b0));
        push_row(nlt_pkg::OP_REPORT, 8'd15, 32'd50, 32'd0, 32'd100, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd120, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd2, 32'd77, 32'd110, 32'd130, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd4, 32'd77, 32'd0, 32'd130, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd0, 32'd77, 32'd0, 32'd140, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'd3, 32'd0, 32'd0, 32'd5000, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd10111, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd0, 32'd10111, 32'd10111, 32'd10111, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, nlt_pkg::BROADCAST_ID, 32'd5, 32'd5, 32'd10112, 0,
                 empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'hFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'h55, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd15, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 0,
                 empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd5, 0, empty_ok);
        push_row(nlt_pkg::OP_REPORT, 8'd9, 32'd3, 32'd0, 32'd9000, 0, empty_ok);
        push_row(nlt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 32'd20000, 0, empty_ok);

        phase_timeout[0] = 32'd1000;
        phase_timeout[1] = 32'd0;
        phase_timeout[2] = 32'hFFFF_FFFF;
        phase_timeout[3] = 32'd50;
        phase_timeout[4] = $urandom_range(100, 20000);
        phase_timeout[5] = nlt_pkg::TIMEOUT_RESET;
        phase_idle[0] = 32;
        phase_idle[1] = 32;
        phase_idle[2] = 70;
        phase_idle[3] = 70;
        phase_idle[4] = 0;
        phase_idle[5] = 0;

        clear_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 32;
        foreach (directed_rows[i])
        begin
            send_transfer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            directed_count++;
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_timeout(phase_timeout[p]);
            sender_idle_pct = phase_idle[p];
            cur_ms = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(30000) : $urandom_range(50000);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_transfer(random_item(), 0, empty_ok);
                random_count++;
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results expected actual none", $time, pending_results.size());
            errors++;
        end
        $display("Ran %0d directed and %0d random transfers under %0d timeout settings.",
                 directed_count, random_count, timeout_writes);
        $display("Checked %0d results, %0d field mismatches.", results_seen, errors);
        if (errors == 0)
        begin
            $display("[node_liveness_table_top] OK");
        end
        else
        begin
            $display("[node_liveness_table_top] ERROR");
        end
        $finish;
    end

endmodule

>>> node_liveness_table_top.f
+incdir+hw/rtl
hw/rtl/nlt_pkg.sv
hw/rtl/nlt_cell.sv
hw/rtl/node_liveness_table_top.sv
tb/node_liveness_table_top_tb.sv
